FILE: rtl/gmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmf_pkg
// Shared types and constants of the grayscale morphology filter.
// ----------------------------------------------------------------------------
package gmf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WINDOW_DEF    = 5;

  localparam int PIX_W      = 8;
  localparam int LINE_SLOTS = 16;
  localparam int SLOT_W     = 4;
  localparam int HEIGHT_CAP = 4096;
  localparam int ROW_W      = 12;
  localparam int H_W        = 13;
  localparam int CFG_WID_W  = 11;
  localparam int MASK_W     = 25;
  localparam int MODE_W     = 2;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [MODE_W-1:0] MODE_DILATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASK   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  localparam logic [MASK_W-1:0]    MASK_RST   = 25'h0EFFFEE;
  localparam logic [CFG_WID_W-1:0] WIDTH_RST  = 11'd512;
  localparam logic [H_W-1:0]       HEIGHT_RST = 13'd512;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // One item slot travelling down the pipeline.
  typedef struct packed {
    logic             tok;   // an item occupies this slot
    logic             have;  // it carries a pixel
    logic [PIX_W-1:0] px;
    logic             last;  // last pixel of an output frame
  } gmf_tok_t;

endpackage

`default_nettype wire

FILE: rtl/grayscale_morphology_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grayscale_morphology_filter
// Flat 5x5 grayscale dilation, erosion, opening and closing on a pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one request per pixel in raster order (in_cmd = 0) or
//   a flush request (in_cmd = 1) that only drains results still owed.
//   Output channel out_*: zero or one filtered pixel per input request, in
//   raster order, out_frame_last marks the last pixel of a frame.
//   cfg_*: register writes (mode, mask, width, height), always ready; write
//   only while the block is idle.
// Throughput: one request per clock while no held result stalls. Each stage
//   reads one column of its banked line store per result (three columns at a
//   line start, one per bank), so the store never limits the rate.
// Path: a request passes the input register, each active stage and the output
//   register. Each stage trails its input by two lines and two pixels.
// Reset: counters and window cleared, registers to opening with the octagon
//   mask on 512x512. Line stores are not cleared.
// Stall: out_stall with a result waiting freezes the whole pipeline and
//   raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module grayscale_morphology_filter
  import gmf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_cmd,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           out_pixel_out,
  output logic                       out_frame_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [MODE_W-1:0]    mode_r;
  logic [MASK_W-1:0]    mask_r;
  logic [CFG_WID_W-1:0] width_r;
  logic [H_W-1:0]       height_r;
  logic [WW-1:0]        img_w;
  logic [H_W-1:0]       img_h;

  logic             en;
  logic             v0_r, cmd0_r;
  logic [PIX_W-1:0] px0_r;
  gmf_tok_t         tok0, s1_out, s2_out, fin;
  logic             second_on;
  logic             out_valid_r, out_last_r;
  logic [PIX_W-1:0] out_px_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OPEN;
      mask_r   <= MASK_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
        REG_MASK:   mask_r   <= cfg_data[MASK_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[CFG_WID_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[H_W-1:0];
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize saturates
  always_comb begin
    if (width_r == '0) begin
      img_w = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      img_w = WW'(MAX_WIDTH);
    end else begin
      img_w = WW'(width_r);
    end
    if (height_r == '0) begin
      img_h = H_W'(1);
    end else if (32'(height_r) > 32'(HEIGHT_CAP)) begin
      img_h = H_W'(HEIGHT_CAP);
    end else begin
      img_h = height_r;
    end
  end

  // advance unless a finished result is held up
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r <= in_cmd;
      px0_r  <= in_pixel_in;
    end
  end

  assign tok0.tok  = v0_r;
  assign tok0.have = v0_r && !cmd0_r;
  assign tok0.px   = px0_r;
  assign tok0.last = 1'b0;

  assign second_on = (mode_r == MODE_OPEN) || (mode_r == MODE_CLOSE);

  gmf_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .active  (1'b1),
    .use_min (mode_r == MODE_ERODE || mode_r == MODE_OPEN),
    .in_tok  (tok0),
    .img_w   (img_w),
    .img_h   (img_h),
    .mask    (mask_r),
    .out_tok (s1_out)
  );

  gmf_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .active  (second_on),
    .use_min (mode_r == MODE_CLOSE),
    .in_tok  (s1_out),
    .img_w   (img_w),
    .img_h   (img_h),
    .mask    (mask_r),
    .out_tok (s2_out)
  );

  assign fin = second_on ? s2_out : s1_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.tok && fin.have;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px_r   <= fin.px;
      out_last_r <= fin.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_px_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/gmf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gmf_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmf_stage
// One max/min window stage: line store banks, position counters, sliding
// window and compare tree. Items pass the second-step registers, then the output register.
// ----------------------------------------------------------------------------
module gmf_stage
  import gmf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             active,
  input  wire logic                             use_min,
  input  wire gmf_tok_t                         in_tok,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   img_w,
  input  wire logic [H_W-1:0]                   img_h,
  input  wire logic [MASK_W-1:0]                mask,
  output gmf_tok_t                              out_tok
);

  localparam int WINDOW = WINDOW_DEF;
  localparam int HALF = WINDOW / 2;
  localparam int K    = HALF + 1;              // column banks
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int XW   = CW + 1;
  localparam int DEP  = (MAX_WIDTH + K - 1) / K;
  localparam int AW   = $clog2(DEP);
  localparam int BW   = $clog2(K);
  localparam int TAPS = WINDOW * WINDOW;
  localparam int P    = 1 << $clog2(TAPS);

  // position state
  logic [CW-1:0]     ic_r, ic_nxt, oc_r, oc_nxt, p_ic, p_oc;
  logic [BW-1:0]     icb_r, icb_nxt, ocb_r, ocb_nxt, p_icb, p_ocb;
  logic [AW-1:0]     ica_r, ica_nxt, oca_r, oca_nxt, p_ica, p_oca;
  logic [ROW_W-1:0]  ir_r, ir_nxt, or_r, or_nxt, p_ir, p_or;
  logic [SLOT_W-1:0] inl_r, inl_nxt, outl_r, outl_nxt, fs_r, fs_nxt, p_inl, p_outl, p_fs;
  logic              ahead_r, ahead_nxt, p_ahead;

  logic step, push, ready, rowstart, last;
  logic [BW-1:0]     rb;
  logic [AW-1:0]     rd_addr;
  logic [SLOT_W-1:0] slot [WINDOW];
  logic              row_ok [WINDOW];
  logic              col_ok [K];
  logic              hit [WINDOW][K];

  // second pipeline step
  logic              b_tok_r, b_emit_r, b_last_r, b_rowstart_r;
  logic [BW-1:0]     b_rb_r;
  logic [SLOT_W-1:0] b_slot_r [WINDOW];
  logic              b_rowok_r [WINDOW];
  logic              b_colok_r [K];
  logic              b_hit_r [WINDOW][K];
  logic [PIX_W-1:0]  b_px_r;

  logic [PIX_W-1:0]  q [LINE_SLOTS][K];
  logic [PIX_W-1:0]  win_r [WINDOW][WINDOW];
  logic [PIX_W-1:0]  win_nxt [WINDOW][WINDOW];
  logic [PIX_W-1:0]  acc;
  gmf_tok_t          out_r;

  assign step = en && active && in_tok.tok;
  assign push = step && in_tok.have;

  // Input side: advance the write position.
  always_comb begin
    logic [XW-1:0]    ic1;
    logic [H_W-1:0]   ir1;
    ic1 = XW'(ic_r) + XW'(1);
    ir1 = H_W'(ir_r) + H_W'(1);
    p_ic = ic_r; p_icb = icb_r; p_ica = ica_r; p_ir = ir_r; p_inl = inl_r;
    p_oc = oc_r; p_ocb = ocb_r; p_oca = oca_r; p_or = or_r; p_outl = outl_r;
    p_fs = fs_r; p_ahead = ahead_r;
    if (in_tok.have) begin
      if (ic1 >= XW'(img_w)) begin
        p_ic  = '0;
        p_icb = '0;
        p_ica = '0;
        p_inl = inl_r + SLOT_W'(1);
        if (ir1 >= img_h) begin
          p_ir = '0;
          // overrun: drop what is owed, restart at the frame just done
          if (ahead_r) begin
            p_oc   = '0;
            p_ocb  = '0;
            p_oca  = '0;
            p_or   = '0;
            p_outl = fs_r;
          end
          p_ahead = 1'b1;
          p_fs    = inl_r + SLOT_W'(1);
        end else begin
          p_ir = ROW_W'(ir1);
        end
      end else begin
        p_ic = CW'(ic1);
        if (icb_r == BW'(K - 1)) begin
          p_icb = '0;
          p_ica = ica_r + AW'(1);
        end else begin
          p_icb = icb_r + BW'(1);
        end
      end
    end
  end

  // Output side: readiness, read addresses, advance the read position.
  always_comb begin
    logic [H_W-1:0] need_r, rowt, or1;
    logic [XW-1:0]  need_c, oc1;
    logic [BW-1:0]  bk;
    need_r = H_W'(p_or) + H_W'(HALF);
    need_c = XW'(p_oc) + XW'(HALF);
    if (need_c > XW'(img_w) - XW'(1)) begin
      need_c = XW'(img_w) - XW'(1);
    end
    ready = p_ahead || (need_r < img_h &&
            (H_W'(p_ir) > need_r || (H_W'(p_ir) == need_r && XW'(p_ic) > need_c)));
    rowstart = (p_oc == '0);
    rb       = (p_ocb == '0) ? BW'(K - 1) : p_ocb - BW'(1);
    rd_addr  = rowstart ? '0 : p_oca + AW'(p_ocb != '0);
    for (int j = 0; j < K; j++) begin
      if (rowstart) begin
        col_ok[j] = XW'(j) < XW'(img_w);
      end else begin
        col_ok[j] = (j == 0) && (XW'(p_oc) + XW'(HALF) < XW'(img_w));
      end
    end
    for (int i = 0; i < WINDOW; i++) begin
      slot[i]   = p_outl + SLOT_W'(i) - SLOT_W'(HALF);
      rowt      = H_W'(p_or) + H_W'(i);
      row_ok[i] = rowt >= H_W'(HALF) && rowt < img_h + H_W'(HALF);
      for (int j = 0; j < K; j++) begin
        bk        = rowstart ? BW'(j) : rb;
        // the pixel written this cycle is not yet in the RAM read data
        hit[i][j] = in_tok.have && inl_r == slot[i] && icb_r == bk && ica_r == rd_addr;
      end
    end
    oc1 = XW'(p_oc) + XW'(1);
    or1 = H_W'(p_or) + H_W'(1);
    last = 1'b0;
    ic_nxt = p_ic; icb_nxt = p_icb; ica_nxt = p_ica; ir_nxt = p_ir; inl_nxt = p_inl;
    oc_nxt = p_oc; ocb_nxt = p_ocb; oca_nxt = p_oca; or_nxt = p_or; outl_nxt = p_outl;
    fs_nxt = p_fs; ahead_nxt = p_ahead;
    if (ready) begin
      if (oc1 >= XW'(img_w)) begin
        oc_nxt   = '0;
        ocb_nxt  = '0;
        oca_nxt  = '0;
        outl_nxt = p_outl + SLOT_W'(1);
        if (or1 >= img_h) begin
          or_nxt    = '0;
          outl_nxt  = p_fs;
          ahead_nxt = 1'b0;
          last      = 1'b1;
        end else begin
          or_nxt = ROW_W'(or1);
        end
      end else begin
        oc_nxt = CW'(oc1);
        if (p_ocb == BW'(K - 1)) begin
          ocb_nxt = '0;
          oca_nxt = p_oca + AW'(1);
        end else begin
          ocb_nxt = p_ocb + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r <= '0; icb_r <= '0; ica_r <= '0; ir_r <= '0; inl_r <= '0;
      oc_r <= '0; ocb_r <= '0; oca_r <= '0; or_r <= '0; outl_r <= '0;
      fs_r <= '0; ahead_r <= 1'b0;
    end else if (step) begin
      ic_r <= ic_nxt; icb_r <= icb_nxt; ica_r <= ica_nxt; ir_r <= ir_nxt; inl_r <= inl_nxt;
      oc_r <= oc_nxt; ocb_r <= ocb_nxt; oca_r <= oca_nxt; or_r <= or_nxt; outl_r <= outl_nxt;
      fs_r <= fs_nxt; ahead_r <= ahead_nxt;
    end
  end

  // line store: one bank per line slot and column phase
  for (genvar s = 0; s < LINE_SLOTS; s++) begin : g_slot
    for (genvar b = 0; b < K; b++) begin : g_bank
      gmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEP)
      ) u_ram (
        .clk   (clk),
        .we    (push && inl_r == SLOT_W'(s) && icb_r == BW'(b)),
        .waddr (ica_r),
        .wdata (in_tok.px),
        .re    (en),
        .raddr (rd_addr),
        .rdata (q[s][b])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tok_r  <= 1'b0;
      b_emit_r <= 1'b0;
      b_last_r <= 1'b0;
    end else if (en) begin
      b_tok_r  <= in_tok.tok;
      b_emit_r <= step && ready;
      b_last_r <= step && ready && last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_rowstart_r <= rowstart;
      b_rb_r       <= rb;
      b_px_r       <= in_tok.px;
      for (int i = 0; i < WINDOW; i++) begin
        b_slot_r[i]  <= slot[i];
        b_rowok_r[i] <= row_ok[i];
        for (int j = 0; j < K; j++) begin
          b_hit_r[i][j] <= hit[i][j];
        end
      end
      for (int j = 0; j < K; j++) begin
        b_colok_r[j] <= col_ok[j];
      end
    end
  end

  // Slide the window, then reduce the masked taps.
  always_comb begin
    logic [PIX_W-1:0] val [WINDOW][K];
    logic [PIX_W-1:0] arr [P];
    logic [PIX_W-1:0] d;
    logic [BW-1:0]    bk;
    logic [P-1:0]     mask_x;
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < K; j++) begin
        bk = b_rowstart_r ? BW'(j) : b_rb_r;
        d  = b_hit_r[i][j] ? b_px_r : q[b_slot_r[i]][bk];
        val[i][j] = (b_rowok_r[i] && b_colok_r[j]) ? d : '0;
      end
      for (int k = 0; k < WINDOW; k++) begin
        if (b_rowstart_r) begin
          win_nxt[i][k] = (k < HALF) ? '0 : val[i][(k >= HALF) ? k - HALF : 0];
        end else if (k < WINDOW - 1) begin
          win_nxt[i][k] = win_r[i][k + 1];
        end else begin
          win_nxt[i][k] = val[i][0];
        end
      end
    end
    mask_x = P'(mask);
    for (int t = 0; t < P; t++) begin
      arr[t] = use_min ? PIX_MAX : '0;
    end
    for (int i = 0; i < WINDOW; i++) begin
      for (int k = 0; k < WINDOW; k++) begin
        if (mask_x[i * WINDOW + k]) begin
          arr[i * WINDOW + k] = win_nxt[i][k];
        end
      end
    end
    for (int s = 1; s < P; s = s * 2) begin
      for (int n = 0; n < P; n = n + 2 * s) begin
        if (use_min) begin
          arr[n] = (arr[n + s] < arr[n]) ? arr[n + s] : arr[n];
        end else begin
          arr[n] = (arr[n + s] > arr[n]) ? arr[n + s] : arr[n];
        end
      end
    end
    acc = arr[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        for (int k = 0; k < WINDOW; k++) begin
          win_r[i][k] <= '0;
        end
      end
    end else if (en && b_emit_r) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.tok  <= 1'b0;
      out_r.have <= 1'b0;
      out_r.last <= 1'b0;
    end else if (en) begin
      out_r.tok  <= b_tok_r;
      out_r.have <= b_emit_r;
      out_r.last <= b_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.px <= acc;
    end
  end

  assign out_tok = out_r;

`ifndef SYNTHESIS
  a_last_has_px: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.last |-> out_r.have) else $error("frame end flag without a pixel");
  a_emit_has_tok: assert property (@(posedge clk) disable iff (!rst_n)
    b_emit_r |-> b_tok_r) else $error("result without an item");
  a_ahead_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(ahead_r) |-> (or_r == '0 && oc_r == '0)) else $error("frame wrap left position");
  a_ahead_set: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ahead_r) |-> (ir_r == '0 && ic_r == '0)) else $error("input frame end mistracked");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_grayscale_morphology_filter.sv
// ----------------------------------------------------------------------------
// tb_grayscale_morphology_filter
// Streams frames of random and extreme pixels with interleaved flush requests
// through the filter under every mode and a range of masks and frame sizes.
// A predictor of both stages runs on every accepted request, and
// each filtered pixel is checked against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_grayscale_morphology_filter;
  import gmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW     = MAX_WIDTH_DEF;
  localparam int WIN      = WINDOW_DEF;
  localparam int HALF     = WIN / 2;
  localparam int LIMIT    = 2_000_000;
  localparam int SETTLE   = 20;
  localparam int N_RANDOM = 250;

  typedef struct {
    logic             cmd;
    logic [PIX_W-1:0] px;
  } req_t;

  typedef struct {
    logic [PIX_W-1:0] px;
    logic             last;
  } pixel_due_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_cmd = 1'b0;
  logic [PIX_W-1:0] in_pixel_in = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, out_frame_last, cfg_ready;
  logic [PIX_W-1:0] out_pixel_out;

  grayscale_morphology_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_out(out_pixel_out),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted configuration and per-stage state (stage 0 first, stage 1 second).
  logic [MODE_W-1:0]    cur_mode   = MODE_OPEN;
  logic [MASK_W-1:0]    cur_mask   = MASK_RST;
  logic [CFG_WID_W-1:0] cur_width  = WIDTH_RST;
  logic [H_W-1:0]       cur_height = HEIGHT_RST;

  logic [PIX_W-1:0] line_mem [2][LINE_SLOTS*MAXW];
  int unsigned in_col[2] = '{0, 0}, in_row[2] = '{0, 0};
  int unsigned out_col[2] = '{0, 0}, out_row[2] = '{0, 0};
  int unsigned in_line[2] = '{0, 0}, out_line[2] = '{0, 0}, frame_base[2] = '{0, 0};
  bit in_ahead[2] = '{0, 0};

  req_t req_q[$];
  pixel_due_t due_q[$];
  int pushed_cnt = 0;
  int accepted_cnt = 0;
  int errs = 0;
  int cyc = 0;
  int in_gap = 0, out_gap = 0;
  bit in_idle = 1'b1, out_idle = 1'b1;
  bit long_hold = 1'b0;
  req_t launch_r;
  pixel_due_t got_d;

  function automatic void store_px(int s, logic [PIX_W-1:0] px, int unsigned w, int unsigned h);
    int unsigned done_base;
    if (in_col[s] < MAXW) line_mem[s][(in_line[s] % LINE_SLOTS) * MAXW + in_col[s]] = px;
    in_col[s]++;
    if (in_col[s] >= w) begin
      in_col[s] = 0;
      in_line[s]++;
      in_row[s]++;
      if (in_row[s] >= h) begin
        done_base = frame_base[s];
        in_row[s] = 0;
        // overrun: drop what is owed and restart on the frame just completed
        if (in_ahead[s]) begin
          out_col[s] = 0;
          out_row[s] = 0;
          out_line[s] = done_base;
        end
        in_ahead[s] = 1'b1;
        frame_base[s] = in_line[s];
      end
    end
  endfunction

  function automatic bit result_ready(int s, int unsigned w, int unsigned h);
    int unsigned need_r, need_c;
    if (in_ahead[s]) return 1'b1;
    need_r = out_row[s] + HALF;
    if (need_r >= h) return 1'b0;
    need_c = out_col[s] + HALF;
    if (need_c > w - 1) need_c = w - 1;
    return in_row[s] > need_r || (in_row[s] == need_r && in_col[s] > need_c);
  endfunction

  function automatic logic [PIX_W-1:0] window_extreme(int s, bit use_min, int unsigned w,
                                                     int unsigned h, output bit last);
    int rr, cc;
    int unsigned slot;
    logic [PIX_W-1:0] acc, v;
    acc = use_min ? PIX_MAX : 8'h00;
    for (int i = 0; i < WIN; i++) begin
      rr = int'(out_row[s]) + i - HALF;
      slot = (out_line[s] + 32'(i) - HALF) % LINE_SLOTS;
      for (int j = 0; j < WIN; j++) begin
        cc = int'(out_col[s]) + j - HALF;
        v = 8'h00;
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w) && cc < MAXW)
          v = line_mem[s][slot * MAXW + cc];
        if (cur_mask[i*WIN + j] && (use_min ? (v < acc) : (v > acc))) acc = v;
      end
    end
    last = 1'b0;
    out_col[s]++;
    if (out_col[s] >= w) begin
      out_col[s] = 0;
      out_line[s]++;
      out_row[s]++;
      if (out_row[s] >= h) begin
        out_row[s] = 0;
        out_line[s] = frame_base[s];
        in_ahead[s] = 1'b0;
        last = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic void filter_item(logic is_flush, logic [PIX_W-1:0] px);
    int unsigned w, h;
    bit have, last;
    logic [PIX_W-1:0] v;
    pixel_due_t d;
    w = cur_width;
    h = cur_height;
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    if (h == 0) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    have = 1'b0;
    last = 1'b0;
    v = '0;
    if (!is_flush) store_px(0, px, w, h);
    if (result_ready(0, w, h)) begin
      v = window_extreme(0, cur_mode == MODE_ERODE || cur_mode == MODE_OPEN, w, h, last);
      have = 1'b1;
    end
    if (cur_mode == MODE_OPEN || cur_mode == MODE_CLOSE) begin
      if (have) store_px(1, v, w, h);
      have = 1'b0;
      if (result_ready(1, w, h)) begin
        v = window_extreme(1, cur_mode == MODE_CLOSE, w, h, last);
        have = 1'b1;
      end
    end
    if (have) begin
      d.px = v;
      d.last = last;
      due_q.push_back(d);
    end
  endfunction

  function automatic bit results_owed();
    return in_ahead[0] || ((cur_mode == MODE_OPEN || cur_mode == MODE_CLOSE) && in_ahead[1]);
  endfunction

  function automatic int draw_gap(bit busy);
    if (busy && $urandom_range(0, 1)) return $urandom_range(0, 17);
    return 0;
  endfunction

  // Driver: launch requests from the pending queue, with random idle gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (req_q.size() != 0) begin
        launch_r = req_q.pop_front();
        in_valid <= 1'b1;
        in_cmd <= launch_r.cmd;
        in_pixel_in <= launch_r.px;
        in_gap <= draw_gap(in_idle);
        if ($urandom_range(0, 99) == 0) in_idle <= ~in_idle;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls after accepted results, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_gap <= draw_gap(out_idle);
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) == 0) out_idle <= ~out_idle;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on accepted requests, check accepted results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        filter_item(in_cmd, in_pixel_in);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          if (errs < 10) $display("unexpected result: pixel %0d last %0b", out_pixel_out,
                                  out_frame_last);
          errs++;
        end else begin
          got_d = due_q.pop_front();
          if (out_pixel_out !== got_d.px || out_frame_last !== got_d.last) begin
            if (errs < 10)
              $display("result mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                       got_d.px, got_d.last, out_pixel_out, out_frame_last);
            errs++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Hold the output off long enough for the block to back up into its input.
  initial begin
    wait (accepted_cnt >= 400);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode = data[MODE_W-1:0];
      REG_MASK:   cur_mask = data[MASK_W-1:0];
      REG_WIDTH:  cur_width = data[CFG_WID_W-1:0];
      REG_HEIGHT: cur_height = data[H_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [MODE_W-1:0] m, logic [MASK_W-1:0] k, int w, int h);
    cfg_write(REG_MODE, CFG_DATA_W'(m));
    cfg_write(REG_MASK, CFG_DATA_W'(k));
    cfg_write(REG_WIDTH, CFG_DATA_W'(w));
    cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic void push_req(logic cmd, logic [PIX_W-1:0] px);
    req_t r;
    r.cmd = cmd;
    r.px = px;
    req_q.push_back(r);
    pushed_cnt++;
  endfunction

  function automatic logic [PIX_W-1:0] rand_px();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return PIX_MAX;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int send_frames(int n, int flush_pct);
    int cnt;
    cnt = 0;
    for (int f = 0; f < n; f++)
      for (int p = 0; p < int'(cur_width) * int'(cur_height); p++) begin
        if ($urandom_range(0, 99) < flush_pct) begin
          push_req(1'b1, 8'($urandom));
          cnt++;
        end
        push_req(1'b0, rand_px());
        cnt++;
      end
    return cnt;
  endfunction

  // Flush until nothing is owed, then let the pipeline go quiet.
  task automatic drain();
    forever begin
      wait (accepted_cnt == pushed_cnt);
      @(posedge clk);
      if (!results_owed()) break;
      repeat (8) push_req(1'b1, 8'($urandom));
    end
    wait (due_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [MASK_W-1:0] rand_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return MASK_RST;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  initial begin
    int n_rand, w, h;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: extremes of the pixel, flush with nothing owed, flush mid-frame.
    set_config(MODE_DILATE, '1, 5, 4);
    push_req(1'b1, PIX_MAX);
    for (int p = 0; p < 20; p++) begin
      if (p == 7 || p == 13) push_req(1'b1, 8'h00);
      push_req(1'b0, (p % 3 == 0) ? PIX_MAX : 8'h00);
    end
    drain();

    // Empty mask under erosion, octagon under opening, the widest line, then 1x1 frames.
    set_config(MODE_ERODE, '0, 3, 3);
    void'(send_frames(1, 10));
    drain();
    set_config(MODE_OPEN, MASK_RST, 6, 5);
    void'(send_frames(2, 5));
    drain();
    set_config(MODE_CLOSE, MASK_RST, MAXW, 1);
    void'(send_frames(1, 2));
    drain();
    set_config(MODE_OPEN, '1, 1, 1);
    void'(send_frames(4, 20));
    drain();

    // Random: small frames back to back, so overruns happen as well.
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      set_config(MODE_W'($urandom_range(0, 3)), rand_mask(), w, h);
      n_rand += send_frames($urandom_range(1, 3), $urandom_range(0, 15));
      drain();
    end

    if (errs == 0 && due_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
